[rtl/core/hslhlg_pkg.sv]
// ----------------------------------------------------------------------------
// hslhlg_pkg: shared types and constants for the HSL to HLG RGB core
// Fixed-point formats, reciprocal constants and the exponential curve table.
// ----------------------------------------------------------------------------
package hslhlg_pkg;

  // Q0.16 unity and one half
  localparam logic [16:0] One  = 17'd65536;
  localparam logic [16:0] Half = 17'd32768;

  // Hue ring in 1/64 degree units
  localparam logic [14:0] HueFull  = 15'd23040;
  localparam logic [11:0] HueSixth = 12'd3840;

  // floor(v / 23040) = (v * HueRecip) >> HueShift, exact for v < 2^28
  localparam logic [27:0] HueRecip = 28'd190887436;
  localparam int          HueShift = 42;
  // floor(v / 15) = (v * FifteenRecip) >> FifteenShift, exact for v < 2^21
  localparam logic [24:0] FifteenRecip = 25'd17895698;
  localparam int          FifteenShift = 28;
  // floor(v / 3) = (v * ThirdRecip) >> ThirdShift, exact for v < 2^27
  localparam logic [28:0] ThirdRecip = 29'd357913942;
  localparam int          ThirdShift = 30;

  // Configuration register indexes
  localparam logic [1:0] CfgBaseHue   = 2'd0;
  localparam logic [1:0] CfgHueStride = 2'd1;
  localparam logic [1:0] CfgBlackLift = 2'd2;
  localparam logic [1:0] CfgGain      = 2'd3;

  localparam logic [14:0] BaseHueReset = 15'd13440;
  localparam logic [23:0] GainReset    = 24'd4700160;

  // Exponential branch table, Q28, one entry per 1/512 of lifted signal above 1/2
  localparam int ExpDepth = 256;
  typedef logic [28:0] curve_rom_t [0:ExpDepth];

  localparam logic [63:0] ArgNum    = 64'd100000000;
  localparam logic [63:0] ArgDen    = 64'd17883277;
  localparam logic [63:0] FourA     = 64'd71533108;
  localparam logic [63:0] OneMinus  = 64'd28466892;
  localparam logic [63:0] CurveDen  = 64'd1200000000;
  localparam logic [63:0] DepthWide = 64'd256;

  function automatic curve_rom_t build_curve();
    curve_rom_t  rom;
    logic [63:0] de;
    logic [63:0] arg;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] y;
    for (int k = 0; k <= ExpDepth; k++) begin
      de   = (64'(k) << 27) / DepthWide;
      arg  = (de * ArgNum) / ArgDen;
      sum  = 64'd1 << 28;
      term = 64'd1 << 28;
      // truncated Taylor sum; once a term hits zero all later ones stay zero
      for (int j = 1; j <= 60; j++) begin
        term = ((term * arg) >> 28) / 64'(j);
        sum  = sum + term;
      end
      y      = (FourA * sum + (OneMinus << 28)) / CurveDen;
      rom[k] = y[28:0];
    end
    return rom;
  endfunction

  localparam curve_rom_t CURVE_ROM = build_curve();

endpackage

[rtl/core/hslhlg_if.sv]
// ----------------------------------------------------------------------------
// hslhlg_if: valid/ready channels of the HSL to HLG RGB core
// Input channel carries hue step, saturation, lightness; output carries RGB.
// ----------------------------------------------------------------------------
interface hslhlg_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] hue_step;
  logic [16:0] saturation;
  logic [16:0] lightness;

  modport source (output valid, output hue_step, output saturation, output lightness,
                  input ready);
  modport sink (input valid, input hue_step, input saturation, input lightness,
                output ready);
endinterface

interface hslhlg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

[rtl/core/hsl_hue_to_hlg_rgb_core.sv]
// ----------------------------------------------------------------------------
// hsl_hue_to_hlg_rgb_core: hue-ring HSL to display RGB via HLG inverse curve
// Thirteen-stage pipeline from hue step, saturation, lightness to RGB.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready beats of hue_step, saturation, lightness (Q0.16).
//   out_ch : valid/ready beats of red, green, blue (16 bit, saturating).
//   cfg_*  : write port; cfg_idx selects base hue, hue stride, black lift or
//            output gain, written when cfg_we is high. Write only while idle.
// Throughput: one beat per cycle unless out_ch.ready stalls the output; every
//   stage holds at most one item and the stages are a register chain (hue
//   reduction, chroma, lift, curve, gain).
// Reset (rst_n low, synchronous): all stage valid bits clear, registers
//   return to base hue 210 degrees, stride 0, no lift, default gain.
// Stall: when out_ch.ready is low the output beat holds; upstream stages keep
//   accepting until every stage is full, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module hsl_hue_to_hlg_rgb_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [23:0]       cfg_wdata,
  hslhlg_in_if.sink         in_ch,
  hslhlg_out_if.source      out_ch
);

  localparam int Stages = 13;

  // configuration
  logic [14:0] base_hue_r;
  logic [14:0] hue_stride_r;
  logic [15:0] black_lift_r;
  logic [23:0] gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_hue_r   <= hslhlg_pkg::BaseHueReset;
      hue_stride_r <= '0;
      black_lift_r <= '0;
      gain_r       <= hslhlg_pkg::GainReset;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        hslhlg_pkg::CfgBaseHue:   base_hue_r   <= cfg_wdata[14:0];
        hslhlg_pkg::CfgHueStride: hue_stride_r <= cfg_wdata[14:0];
        hslhlg_pkg::CfgBlackLift: black_lift_r <= cfg_wdata[15:0];
        hslhlg_pkg::CfgGain:      gain_r       <= cfg_wdata;
      endcase
    end
  end

  // stage control: a stage advances when empty or when its successor advances
  logic [Stages:1] vld_r;
  logic [Stages:1] vld_nxt;
  logic [Stages:1] en;

  always_comb begin
    en[Stages] = !vld_r[Stages] || out_ch.ready;
    for (int k = Stages - 1; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign vld_nxt = {vld_r[Stages-1:1], in_ch.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 1; k <= Stages; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  assign in_ch.ready  = en[1];
  assign out_ch.valid = vld_r[Stages];

  function automatic logic [16:0] clamp_one(input logic [17:0] v);
    clamp_one = (v > 18'(hslhlg_pkg::One)) ? hslhlg_pkg::One : v[16:0];
  endfunction

  // ---- stage 1: clamp, hue product, chroma ---------------------------------
  logic [16:0] s1_sat;
  logic [16:0] s1_l_nxt;
  logic [17:0] s1_two_l;
  logic [16:0] s1_absd;
  logic [16:0] s1_one_m;
  logic [33:0] s1_cprod;
  logic [26:0] s1_hp_nxt;
  logic [26:0] s1_hp_r;
  logic [16:0] s1_c_r;
  logic [16:0] s1_l_r;

  always_comb begin
    s1_sat   = clamp_one({1'b0, in_ch.saturation});
    s1_l_nxt = clamp_one({1'b0, in_ch.lightness});
    s1_two_l = {s1_l_nxt, 1'b0};
    s1_absd  = (s1_two_l >= 18'(hslhlg_pkg::One)) ?
               17'(s1_two_l - 18'(hslhlg_pkg::One)) :
               17'(18'(hslhlg_pkg::One) - s1_two_l);
    s1_one_m = hslhlg_pkg::One - s1_absd;
    s1_cprod = 34'(s1_one_m) * 34'(s1_sat);
    s1_hp_nxt = 27'(in_ch.hue_step) * 27'(hue_stride_r);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_hp_r <= s1_hp_nxt;
      s1_c_r  <= s1_cprod[32:16];
      s1_l_r  <= s1_l_nxt;
    end
  end

  // ---- stage 2: hue sum ---------------------------------------------------
  logic [27:0] s2_hsum_r;
  logic [16:0] s2_c_r;
  logic [16:0] s2_l_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_hsum_r <= 28'(s1_hp_r) + 28'(base_hue_r);
      s2_c_r    <= s1_c_r;
      s2_l_r    <= s1_l_r;
    end
  end

  // ---- stage 3: quotient by the full circle -------------------------------
  logic [55:0] s3_qprod;
  logic [12:0] s3_q_r;
  logic [27:0] s3_hsum_r;
  logic [16:0] s3_c_r;
  logic [16:0] s3_l_r;

  assign s3_qprod = 56'(s2_hsum_r) * 56'(hslhlg_pkg::HueRecip);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_q_r    <= s3_qprod[hslhlg_pkg::HueShift +: 13];
      s3_hsum_r <= s2_hsum_r;
      s3_c_r    <= s2_c_r;
      s3_l_r    <= s2_l_r;
    end
  end

  // ---- stage 4: hue remainder ---------------------------------------------
  logic [27:0] s4_rem;
  logic [14:0] s4_h_r;
  logic [16:0] s4_c_r;
  logic [16:0] s4_l_r;

  assign s4_rem = s3_hsum_r - 28'(28'(s3_q_r) * 28'(hslhlg_pkg::HueFull));

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_h_r <= s4_rem[14:0];
      s4_c_r <= s3_c_r;
      s4_l_r <= s3_l_r;
    end
  end

  // ---- stage 5: sector and distance from the sector edge ------------------
  logic [2:0]  s5_sec_nxt;
  logic [14:0] s5_within;
  logic [11:0] s5_dist;
  logic [2:0]  s5_sec_r;
  logic [11:0] s5_wt_r;
  logic [16:0] s5_c_r;
  logic [16:0] s5_l_r;

  always_comb begin
    priority if (s4_h_r >= 15'(5 * 3840)) s5_sec_nxt = 3'd5;
    else if (s4_h_r >= 15'(4 * 3840))     s5_sec_nxt = 3'd4;
    else if (s4_h_r >= 15'(3 * 3840))     s5_sec_nxt = 3'd3;
    else if (s4_h_r >= 15'(2 * 3840))     s5_sec_nxt = 3'd2;
    else if (s4_h_r >= 15'(3840))         s5_sec_nxt = 3'd1;
    else                                  s5_sec_nxt = 3'd0;

    priority if (s4_h_r >= 15'(4 * 3840)) s5_within = s4_h_r - 15'(4 * 3840);
    else if (s4_h_r >= 15'(2 * 3840))     s5_within = s4_h_r - 15'(2 * 3840);
    else                                  s5_within = s4_h_r;

    s5_dist = (s5_within >= 15'(hslhlg_pkg::HueSixth)) ?
              12'(s5_within - 15'(hslhlg_pkg::HueSixth)) :
              12'(15'(hslhlg_pkg::HueSixth) - s5_within);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_sec_r <= s5_sec_nxt;
      s5_wt_r  <= hslhlg_pkg::HueSixth - s5_dist;
      s5_c_r   <= s4_c_r;
      s5_l_r   <= s4_l_r;
    end
  end

  // ---- stage 6: X numerator -----------------------------------------------
  logic [28:0] s6_xp_r;
  logic [2:0]  s6_sec_r;
  logic [16:0] s6_c_r;
  logic [16:0] s6_l_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_xp_r  <= 29'(s5_c_r) * 29'(s5_wt_r);
      s6_sec_r <= s5_sec_r;
      s6_c_r   <= s5_c_r;
      s6_l_r   <= s5_l_r;
    end
  end

  // ---- stage 7: X = numerator / 3840 (shift by 256, then divide by 15) ----
  logic [45:0] s7_xprod;
  logic [16:0] s7_x_r;
  logic [2:0]  s7_sec_r;
  logic [16:0] s7_c_r;
  logic [16:0] s7_l_r;

  assign s7_xprod = 46'(s6_xp_r[28:8]) * 46'(hslhlg_pkg::FifteenRecip);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_x_r   <= s7_xprod[hslhlg_pkg::FifteenShift +: 17];
      s7_sec_r <= s6_sec_r;
      s7_c_r   <= s6_c_r;
      s7_l_r   <= s6_l_r;
    end
  end

  // ---- stage 8: sector mapping to R, G, B ---------------------------------
  logic [16:0] s8_m;
  logic [16:0] s8_cm;
  logic [16:0] s8_xm;
  logic [16:0] s8_e_nxt [0:2];
  logic [16:0] s8_e_r   [0:2];

  always_comb begin
    s8_m  = s7_l_r - {1'b0, s7_c_r[16:1]};
    s8_cm = clamp_one(18'(s7_c_r) + 18'(s8_m));
    s8_xm = clamp_one(18'(s7_x_r) + 18'(s8_m));
    case (s7_sec_r)
      3'd0:    begin s8_e_nxt[0] = s8_cm; s8_e_nxt[1] = s8_xm; s8_e_nxt[2] = s8_m;  end
      3'd1:    begin s8_e_nxt[0] = s8_xm; s8_e_nxt[1] = s8_cm; s8_e_nxt[2] = s8_m;  end
      3'd2:    begin s8_e_nxt[0] = s8_m;  s8_e_nxt[1] = s8_cm; s8_e_nxt[2] = s8_xm; end
      3'd3:    begin s8_e_nxt[0] = s8_m;  s8_e_nxt[1] = s8_xm; s8_e_nxt[2] = s8_cm; end
      3'd4:    begin s8_e_nxt[0] = s8_xm; s8_e_nxt[1] = s8_m;  s8_e_nxt[2] = s8_cm; end
      default: begin s8_e_nxt[0] = s8_cm; s8_e_nxt[1] = s8_m;  s8_e_nxt[2] = s8_xm; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_e_r <= s8_e_nxt;
    end
  end

  // ---- stage 9: black-level lift ------------------------------------------
  logic [32:0] s9_lp   [0:2];
  logic [16:0] s9_lift_r [0:2];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s9_lp[j] = 33'(black_lift_r) * 33'(hslhlg_pkg::One - s8_e_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      for (int j = 0; j < 3; j++) begin
        s9_lift_r[j] <= s8_e_r[j] + s9_lp[j][32:16];
      end
    end
  end

  // ---- stage 10: square branch product, table read and slope product ------
  logic        s10_up_nxt [0:2];
  logic [26:0] s10_sq_nxt [0:2];
  logic [28:0] s10_ti_nxt [0:2];
  logic [28:0] s10_ip_nxt [0:2];
  logic        s10_up_r   [0:2];
  logic [26:0] s10_sq_r   [0:2];
  logic [28:0] s10_ti_r   [0:2];
  logic [28:0] s10_ip_r   [0:2];

  always_comb begin
    logic [33:0] sq;
    logic [16:0] dl;
    logic [8:0]  idx;
    logic [8:0]  idx1;
    logic [28:0] ti1;
    logic [28:0] d;
    logic [35:0] ip;
    for (int j = 0; j < 3; j++) begin
      s10_up_nxt[j] = s9_lift_r[j] > hslhlg_pkg::Half;
      sq            = 34'(s9_lift_r[j]) * 34'(s9_lift_r[j]);
      s10_sq_nxt[j] = sq[30:4];
      dl            = s9_lift_r[j] - hslhlg_pkg::Half;
      idx           = s10_up_nxt[j] ? dl[15:7] : 9'd0;
      idx1          = (idx == 9'(hslhlg_pkg::ExpDepth)) ? idx : idx + 9'd1;
      s10_ti_nxt[j] = hslhlg_pkg::CURVE_ROM[idx];
      ti1           = hslhlg_pkg::CURVE_ROM[idx1];
      d             = ti1 - s10_ti_nxt[j];
      ip            = 36'(d) * 36'(dl[6:0]);
      s10_ip_nxt[j] = ip[35:7];
    end
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s10_up_r <= s10_up_nxt;
      s10_sq_r <= s10_sq_nxt;
      s10_ti_r <= s10_ti_nxt;
      s10_ip_r <= s10_ip_nxt;
    end
  end

  // ---- stage 11: divide square by three or finish interpolation -----------
  logic [55:0] s11_third [0:2];
  logic [28:0] s11_y_r   [0:2];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s11_third[j] = 56'(s10_sq_r[j]) * 56'(hslhlg_pkg::ThirdRecip);
    end
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      for (int j = 0; j < 3; j++) begin
        s11_y_r[j] <= s10_up_r[j] ? s10_ti_r[j] + s10_ip_r[j] :
                      29'(s11_third[j][55:hslhlg_pkg::ThirdShift]);
      end
    end
  end

  // ---- stage 12: output gain ----------------------------------------------
  logic [52:0] s12_prod [0:2];
  logic [16:0] s12_p_r  [0:2];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s12_prod[j] = 53'(s11_y_r[j]) * 53'(gain_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en[12]) begin
      for (int j = 0; j < 3; j++) begin
        s12_p_r[j] <= s12_prod[j][52:36];
      end
    end
  end

  // ---- stage 13: saturate and hold the output beat ------------------------
  logic [15:0] s13_out_r [0:2];

  always_ff @(posedge clk) begin
    if (en[13]) begin
      for (int j = 0; j < 3; j++) begin
        s13_out_r[j] <= s12_p_r[j][16] ? 16'hFFFF : s12_p_r[j][15:0];
      end
    end
  end

  assign out_ch.red   = s13_out_r[0];
  assign out_ch.green = s13_out_r[1];
  assign out_ch.blue  = s13_out_r[2];

endmodule
